// ----- hdl/bile_pkg.sv -----
// ----------------------------------------------------------------------------
// bile_pkg
// types and constants shared by the ordered list engine
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package bile_pkg;
	localparam int unsigned DEPTH = 16;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam int unsigned POS_W = $clog2(DEPTH);
	localparam int unsigned QDEPTH = 2;

	typedef enum logic [2:0] {
		ACT_APPEND = 3'd0,
		ACT_PUSH   = 3'd1,
		ACT_SORTED = 3'd2,
		ACT_REMOVE = 3'd3,
		ACT_POP    = 3'd4
	} action_t;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [1:0] ST_EMPTY     = 2'd2;
	localparam logic [1:0] ST_FULL      = 2'd3;

	typedef enum logic [1:0] {
		OP_NONE,
		OP_INSERT,
		OP_SORTED,
		OP_REMOVE
	} op_t;

	// classified request passed from front to back
	typedef struct packed {
		op_t         op;
		logic        at_head;
		logic signed [15:0] value;
	} req_t;
endpackage
`default_nettype wire

// ----- hdl/bile_front.sv -----
// ----------------------------------------------------------------------------
// bile_front
// accepts requests, classifies them and queues them for the list unit
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module bile_front (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               valid,
	output logic                    stall,
	input  wire logic [2:0]         action,
	input  wire logic signed [15:0] value,
	output logic                    req_valid,
	input  wire logic               req_take,
	output bile_pkg::req_t          req
);
	bile_pkg::req_t q_mem_q [bile_pkg::QDEPTH];
	logic           wr_ptr_q, rd_ptr_q;
	logic [1:0]     fill_q;
	bile_pkg::req_t cls;
	logic           push, pop;

	always_comb begin
		cls.value   = value;
		cls.at_head = 1'b0;
		case (action)
			bile_pkg::ACT_APPEND: cls.op = bile_pkg::OP_INSERT;
			bile_pkg::ACT_PUSH: begin
				cls.op      = bile_pkg::OP_INSERT;
				cls.at_head = 1'b1;
			end
			bile_pkg::ACT_SORTED: cls.op = bile_pkg::OP_SORTED;
			bile_pkg::ACT_REMOVE: cls.op = bile_pkg::OP_REMOVE;
			bile_pkg::ACT_POP: begin
				cls.op      = bile_pkg::OP_REMOVE;
				cls.at_head = 1'b1;
			end
			default: cls.op = bile_pkg::OP_NONE;
		endcase
	end

	assign stall     = (fill_q == 2'(bile_pkg::QDEPTH));
	assign push      = valid && !stall;
	assign req_valid = (fill_q != 2'd0);
	assign pop       = req_valid && req_take;
	assign req       = q_mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) q_mem_q[wr_ptr_q] <= cls;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (pop) rd_ptr_q <= !rd_ptr_q;
			fill_q <= fill_q + 2'(push) - 2'(pop);
		end
	end

`ifndef SYNTHESIS
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= 2'(bile_pkg::QDEPTH)) else $error("queue overfilled");
	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(fill_q == 2'd1) |-> (wr_ptr_q != rd_ptr_q)) else $error("pointer mismatch");
	a_fill_step: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (fill_q == $past(fill_q) + 2'd1)) else $error("fill step");
`endif
endmodule
`default_nettype wire

// ----- hdl/bile_back.sv -----
// ----------------------------------------------------------------------------
// bile_back
// cell chain list: all cells compare at once, then all cells shift on the same cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module bile_back (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                req_valid,
	output logic                     req_take,
	input  wire bile_pkg::req_t      req,
	output logic                     valid,
	input  wire logic                stall,
	output logic signed [15:0]       out_value,
	output logic [1:0]               status,
	output logic [4:0]               entry_count,
	output logic                     is_empty
);
	localparam int unsigned D = bile_pkg::DEPTH;
	localparam int unsigned CW = bile_pkg::CNT_W;
	localparam int unsigned PW = bile_pkg::POS_W;

	logic signed [15:0] cells_q [D];
	logic [CW-1:0]      count_q;
	logic [D-1:0]       live, gt_v, eq_v;
	bile_pkg::req_t     req_s1;
	logic               busy_s1;
	logic [D-1:0]       gt_s1, eq_s1;
	logic               out_full;
	logic               do_ins, do_rem;
	logic [PW-1:0]      pos;
	logic               found;
	logic [1:0]         st;
	logic signed [15:0] rem_val;

	for (genvar i = 0; i < D; i++) begin : g_cmp
		assign live[i] = (CW'(i) < count_q);
		assign gt_v[i] = live[i] && (cells_q[i] > req.value);
		assign eq_v[i] = live[i] && (cells_q[i] == req.value);
	end

	assign out_full = valid && stall;
	assign req_take = req_valid && !busy_s1;

	// position: head, tail (count), or first set bit of the registered match vectors
	always_comb begin
		logic [D-1:0] v;
		v = (req_s1.op == bile_pkg::OP_SORTED) ? gt_s1 : eq_s1;
		pos   = PW'(count_q);
		found = 1'b0;
		if (req_s1.at_head) begin
			pos   = '0;
			found = 1'b1;
		end else if (req_s1.op == bile_pkg::OP_SORTED || req_s1.op == bile_pkg::OP_REMOVE) begin
			for (int i = D - 1; i >= 0; i--) begin
				if (v[i]) begin
					pos   = PW'(i);
					found = 1'b1;
				end
			end
		end
	end

	always_comb begin
		st     = bile_pkg::ST_OK;
		do_ins = 1'b0;
		do_rem = 1'b0;
		case (req_s1.op)
			bile_pkg::OP_INSERT, bile_pkg::OP_SORTED: begin
				if (count_q == CW'(D)) st = bile_pkg::ST_FULL;
				else do_ins = 1'b1;
			end
			bile_pkg::OP_REMOVE: begin
				if (count_q == '0) st = bile_pkg::ST_EMPTY;
				else if (!found) st = bile_pkg::ST_NOT_FOUND;
				else do_rem = 1'b1;
			end
			default: st = bile_pkg::ST_OK;
		endcase
	end

	assign rem_val = cells_q[pos];

	always_ff @(posedge clk) begin
		if (req_take) begin
			req_s1 <= req;
			gt_s1  <= gt_v;
			eq_s1  <= eq_v;
		end
		if (busy_s1 && !out_full) begin
			for (int i = 0; i < D; i++) begin
				if (do_ins) begin
					if (PW'(i) == pos) cells_q[i] <= req_s1.value;
					else if (PW'(i) > pos && i > 0) cells_q[i] <= cells_q[(i + D - 1) % D];
				end else if (do_rem) begin
					if (PW'(i) >= pos && i < D - 1) cells_q[i] <= cells_q[(i + 1) % D];
				end
			end
			out_value <= do_rem ? rem_val : 16'sd0;
			status    <= st;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_s1 <= 1'b0;
			count_q <= '0;
			valid   <= 1'b0;
		end else begin
			if (req_take) busy_s1 <= 1'b1;
			else if (busy_s1 && !out_full) busy_s1 <= 1'b0;
			if (busy_s1 && !out_full) begin
				valid <= 1'b1;
				if (do_ins) count_q <= count_q + CW'(1);
				else if (do_rem) count_q <= count_q - CW'(1);
			end else if (valid && !stall) begin
				valid <= 1'b0;
			end
		end
	end

	assign entry_count = 5'(count_q);
	assign is_empty    = (count_q == '0);

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(D)) else $error("count above depth");
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(busy_s1) |-> (count_q == $past(count_q))) else $error("count moved idle");
	a_no_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy_s1 |-> !req_take) else $error("took while busy");
`endif
endmodule
`default_nettype wire

// ----- hdl/bounded_integer_list_engine.sv -----
// result path: queue entry, compare stage register, then result register when the result side is free
// a new transaction is taken only after the compare then shift of the last one in the cell chain
// a two-entry queue separates request intake from the list cells
// reset: asynchronous active-low arst_n empties the list and the queue
// ----------------------------------------------------------------------------
// bounded_integer_list_engine
// ordered list of signed values with insert, remove and pop requests
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module bounded_integer_list_engine (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [2:0]         action,
	input  wire logic signed [15:0] value,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic signed [15:0]      out_value,
	output logic [1:0]              status,
	output logic [4:0]              entry_count,
	output logic                    is_empty
);
	bile_pkg::req_t req;
	logic           req_valid, req_take;

	bile_front u_front (
		.clk, .arst_n,
		.valid(in_valid), .stall(in_stall), .action, .value,
		.req_valid, .req_take, .req
	);

	bile_back u_back (
		.clk, .arst_n,
		.req_valid, .req_take, .req,
		.valid(out_valid), .stall(out_stall),
		.out_value, .status, .entry_count, .is_empty
	);
endmodule
`default_nettype wire

// ----- tb/tb_bounded_integer_list_engine.sv -----
// ----------------------------------------------------------------------------
// tb_bounded_integer_list_engine
// checks the ordered list engine against a behavioral list kept in a queue;
// directed fill, drain, search and empty cases, then random requests with
// random gaps and stalls on both sides and one long output hold-off
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module tb_bounded_integer_list_engine;
	typedef struct packed {
		logic signed [15:0] rv;
		logic [1:0]         st;
		logic [4:0]         cnt;
		logic               emp;
	} outcome_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic [2:0] action = '0;
	logic signed [15:0] value = '0;
	logic out_stall = 1'b0;
	logic in_stall, out_valid, is_empty;
	logic signed [15:0] out_value;
	logic [1:0] status;
	logic [4:0] entry_count;

	logic signed [15:0] model_list[$];
	outcome_t pending_outcomes[$];
	int errors = 0;
	int sent = 0;
	int received = 0;
	bit hold_off = 1'b0;

	bounded_integer_list_engine dut (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.action(action), .value(value), .out_valid(out_valid), .out_stall(out_stall),
		.out_value(out_value), .status(status), .entry_count(entry_count),
		.is_empty(is_empty)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic outcome_t apply_request(logic [2:0] act, logic signed [15:0] v);
		outcome_t o;
		int k;
		o = '0;
		case (act)
			bile_pkg::ACT_APPEND, bile_pkg::ACT_PUSH, bile_pkg::ACT_SORTED: begin
				if (model_list.size() >= bile_pkg::DEPTH) o.st = bile_pkg::ST_FULL;
				else if (act == bile_pkg::ACT_APPEND) model_list.push_back(v);
				else if (act == bile_pkg::ACT_PUSH) model_list.push_front(v);
				else begin
					k = 0;
					while (k < model_list.size() && model_list[k] <= v) k++;
					model_list.insert(k, v);
				end
			end
			bile_pkg::ACT_REMOVE: begin
				if (model_list.size() == 0) o.st = bile_pkg::ST_EMPTY;
				else begin
					k = 0;
					while (k < model_list.size() && model_list[k] != v) k++;
					if (k < model_list.size()) begin
						o.rv = model_list[k];
						model_list.delete(k);
					end else o.st = bile_pkg::ST_NOT_FOUND;
				end
			end
			bile_pkg::ACT_POP: begin
				if (model_list.size() == 0) o.st = bile_pkg::ST_EMPTY;
				else o.rv = model_list.pop_front();
			end
			default: ;
		endcase
		o.cnt = 5'(model_list.size());
		o.emp = (model_list.size() == 0);
		return o;
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		$display("mismatch on result %0d: %s got %0d expected %0d", received, what, got, want);
		errors++;
	endtask

	// idle gap after a transaction; valid drops only when a gap follows
	task automatic random_gap(int pct);
		int n;
		n = 0;
		if ($urandom_range(99) < pct)
			n = ($urandom_range(9) == 0) ? $urandom_range(30, 8) : $urandom_range(3, 1);
		if (n > 0) begin
			in_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	task automatic send_request(logic [2:0] act, logic signed [15:0] v);
		action <= act;
		value <= v;
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		pending_outcomes.push_back(apply_request(act, v));
		sent++;
		random_gap(30);
	endtask

	// output side stall
	initial begin
		forever begin
			@(posedge clk);
			if (hold_off) out_stall <= 1'b1;
			else if ($urandom_range(99) < 25) out_stall <= 1'b1;
			else out_stall <= 1'b0;
		end
	end

	// result checker
	initial begin
		outcome_t w;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && !out_stall) begin
				if (pending_outcomes.size() == 0) begin
					report_mismatch("unexpected result, pending count", 1, 0);
				end else begin
					w = pending_outcomes.pop_front();
					if (out_value !== w.rv) report_mismatch("out_value", out_value, w.rv);
					if (status !== w.st) report_mismatch("status", status, w.st);
					if (entry_count !== w.cnt) report_mismatch("entry_count", entry_count, w.cnt);
					if (is_empty !== w.emp) report_mismatch("is_empty", is_empty, w.emp);
				end
				received++;
			end
		end
	end

	task automatic test_empty_list();
		send_request(bile_pkg::ACT_POP, 16'sd5);
		send_request(bile_pkg::ACT_REMOVE, -16'sd1);
		send_request(3'd5, 16'sd0);
		send_request(3'd7, -16'sd32768);
	endtask

	task automatic test_fill_to_full();
		send_request(bile_pkg::ACT_SORTED, 16'sd32767);
		send_request(bile_pkg::ACT_SORTED, -16'sd32768);
		send_request(bile_pkg::ACT_SORTED, 16'sd0);
		send_request(bile_pkg::ACT_SORTED, 16'sd0);
		send_request(bile_pkg::ACT_APPEND, -16'sd1);
		send_request(bile_pkg::ACT_PUSH, 16'sd21845);
		while (model_list.size() < bile_pkg::DEPTH)
			send_request(3'($urandom_range(2)), 16'($urandom));
		send_request(bile_pkg::ACT_APPEND, 16'sd1);
		send_request(bile_pkg::ACT_PUSH, 16'sd2);
		send_request(bile_pkg::ACT_SORTED, 16'sd3);
	endtask

	task automatic test_remove_and_drain();
		send_request(bile_pkg::ACT_REMOVE, 16'sd0);
		send_request(bile_pkg::ACT_REMOVE, 16'sd12345);
		send_request(bile_pkg::ACT_REMOVE, 16'sd32767);
		while (model_list.size() > 0) send_request(bile_pkg::ACT_POP, 16'($urandom));
	endtask

	task automatic test_random_requests(int count);
		logic [2:0] act;
		logic signed [15:0] v;
		int r;
		repeat (count) begin
			r = $urandom_range(99);
			if (r < 45) act = 3'($urandom_range(2));
			else if (r < 70) act = bile_pkg::ACT_REMOVE;
			else if (r < 95) act = bile_pkg::ACT_POP;
			else act = 3'($urandom_range(7, 5));
			// mostly small values so duplicates and hits occur
			if ($urandom_range(3) == 0) v = 16'($urandom);
			else v = 16'(int'($urandom_range(16)) - 8);
			if (act == bile_pkg::ACT_REMOVE && model_list.size() > 0 && $urandom_range(1))
				v = model_list[$urandom_range(model_list.size() - 1)];
			send_request(act, v);
		end
	endtask

	task automatic test_output_hold_off();
		fork
			begin
				hold_off = 1'b1;
				repeat (60) @(posedge clk);
				hold_off = 1'b0;
			end
			repeat (12) send_request(3'($urandom_range(4)), 16'($urandom));
		join
	endtask

	initial begin
		int guard;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_list();
		test_fill_to_full();
		test_remove_and_drain();
		test_output_hold_off();
		test_random_requests(380);
		in_valid <= 1'b0;
		guard = 0;
		while (pending_outcomes.size() > 0 && guard < 10000) begin
			@(posedge clk);
			guard++;
		end
		repeat (10) @(posedge clk);
		$display("sent %0d requests covering fill, overflow, search, drain and empty cases,",
			sent);
		$display("checked %0d results under random gaps and stalls", received);
		if (errors == 0 && pending_outcomes.size() == 0)
			$display("** bounded_integer_list_engine: PASSED **");
		else
			$display("** bounded_integer_list_engine: FAILED **");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("timeout");
		$display("** bounded_integer_list_engine: FAILED **");
		$finish;
	end
endmodule
`default_nettype wire

// ----- filelist.f -----
hdl/bile_pkg.sv
hdl/bile_front.sv
hdl/bile_back.sv
hdl/bounded_integer_list_engine.sv
tb/tb_bounded_integer_list_engine.sv
